@@ rtl/rrts_pkg.sv @@
package rrts_pkg;

  // Request kinds carried on s_tuser.
  localparam logic [1:0] MODE_CREATE = 2'd0;
  localparam logic [1:0] MODE_YIELD  = 2'd1;
  localparam logic [1:0] MODE_EXIT   = 2'd2;

  // Response kinds carried on m_tuser.
  localparam logic [1:0] STATUS_CREATED  = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_SWITCHED = 2'd2;
  localparam logic [1:0] STATUS_NONE     = 2'd3;

  // Per-slot state.
  localparam logic [1:0] SLOT_UNUSED  = 2'd0;
  localparam logic [1:0] SLOT_READY   = 2'd1;
  localparam logic [1:0] SLOT_RUNNING = 2'd2;

  localparam int ADDR_W     = 32;
  localparam int INDEX_W    = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;
  localparam int APB_ADDR_W = 2;

  localparam logic [APB_ADDR_W-1:0] REG_STACK_BASE = 2'd0;

  // Commands from the sequencer to the slot table.
  typedef struct packed {
    logic seek_unused;  // scan compares against unused instead of ready
    logic free_cur;     // mark the current slot unused
    logic create_set;   // mark the scanned slot ready
    logic switch_set;   // scanned slot runs, the old current one goes back to ready
  } slot_cmd_t;

endpackage

@@ rtl/round_robin_task_scheduler_core.sv @@
// Round-robin task scheduler. Each request on the s_ side (create, yield or exit, kind on
// s_tuser) yields exactly one response on the m_ side, with its kind on m_tuser. The
// block handles one request at a time: the request is taken in the idle state, then a
// single compare unit walks the slot table one slot per cycle, starting at slot 0 for a
// create and at the slot after the current task (slot 0 if there is none) for a yield
// or exit, and stops at the first match or once every slot has been examined. On a
// match the hit state updates the table and, for a create, the entry memory; the
// finish state then forms the response, waiting while a previous response is still held
// on m_tready. A request of the unused kind skips the scan. The initial stack pointer is
// stack_region_base + (slot + 1) * STACK_BYTES - 4, modulo 2^32. stack_region_base lies
// at APB address 0 and should be written only while no request is in flight.
module round_robin_task_scheduler_core
  import rrts_pkg::*;
#(
  parameter int TASK_SLOTS  = 16,
  parameter int STACK_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // Request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] entry_address
  input  logic [1:0]            s_tuser,   // [1:0] mode
  // Response stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] task_index, [7:4] previous_index,
                                           // [8] previous_valid, [40:9] start_address,
                                           // [72:41] initial_stack, [79:73] zero
  output logic [1:0]            m_tuser    // [1:0] status
);

  localparam int SLOT_W = $clog2(TASK_SLOTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_FINISH
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   ptr;
  logic [SLOT_W-1:0]   cnt;
  logic [1:0]          mode_q;
  logic [ADDR_W-1:0]   entry_q;
  logic                found;
  logic [ADDR_W-1:0]   prod;
  logic [SLOT_W-1:0]   prev_idx;
  logic                prev_ok;
  logic                cur_valid;
  logic [SLOT_W-1:0]   cur_slot;
  logic [ADDR_W-1:0]   stack_base;

  slot_cmd_t           cmd;
  logic                hit;
  logic                accept;
  logic                is_create;
  logic [SLOT_W-1:0]   ptr_wrap;
  logic [SLOT_W-1:0]   cur_wrap;
  logic [SLOT_W:0]     ptr_inc;
  logic [ADDR_W-1:0]   ram_rdata;
  logic [ADDR_W-1:0]   start_addr;
  logic [ADDR_W-1:0]   stack_ptr;
  logic [7:0]          idx_wide;
  logic [7:0]          prev_wide;
  logic [1:0]          status_out;
  logic                cfg_write;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_STACK_BASE);
  assign prdata    = (paddr == REG_STACK_BASE) ? stack_base : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_base <= '0;
    end else if (cfg_write) begin
      stack_base <= pwdata;
    end
  end

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_create = (mode_q == MODE_CREATE);

  assign ptr_wrap = (ptr == SLOT_W'(TASK_SLOTS - 1)) ? '0 : ptr + 1'b1;
  assign cur_wrap = (cur_slot == SLOT_W'(TASK_SLOTS - 1)) ? '0 : cur_slot + 1'b1;
  assign ptr_inc  = {1'b0, ptr} + (SLOT_W + 1)'(1);

  always_comb begin
    cmd             = '0;
    cmd.seek_unused = is_create;
    cmd.free_cur    = accept && (s_tuser == MODE_EXIT) && cur_valid;
    cmd.create_set  = (state == ST_HIT) && is_create;
    cmd.switch_set  = (state == ST_HIT) && !is_create;
  end

  rrts_slot_table #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ptr       (ptr),
    .cur_valid (cur_valid),
    .cur_slot  (cur_slot),
    .hit       (hit)
  );

  // Entry addresses; the read port follows the scan pointer so the chosen
  // slot's entry is registered and ready in the cycle after the hit.
  rrts_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TASK_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.create_set),
    .waddr (ptr),
    .wdata (entry_q),
    .raddr (ptr),
    .rdata (ram_rdata)
  );

  assign start_addr = is_create ? entry_q : ram_rdata;
  assign stack_ptr  = stack_base + prod - 32'd4;
  assign idx_wide   = 8'(ptr);
  assign prev_wide  = 8'(prev_idx);

  always_comb begin
    if (found) begin
      status_out = is_create ? STATUS_CREATED : STATUS_SWITCHED;
    end else begin
      status_out = is_create ? STATUS_FULL : STATUS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_valid <= 1'b0;
      cur_slot  <= '0;
      m_tvalid  <= 1'b0;
      found     <= 1'b0;
      ptr       <= '0;
      cnt       <= '0;
      mode_q    <= MODE_CREATE;
    end else begin
      // In the finish state the response register is reloaded below instead.
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            mode_q  <= s_tuser;
            entry_q <= s_tdata;
            cnt     <= '0;
            found   <= 1'b0;
            if (s_tuser == MODE_CREATE) begin
              ptr   <= '0;
              state <= ST_SCAN;
            end else if (s_tuser == MODE_YIELD || s_tuser == MODE_EXIT) begin
              ptr   <= cur_valid ? cur_wrap : '0;
              state <= ST_SCAN;
            end else begin
              // Unused request kind: answered as no ready task.
              state <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          if (hit) begin
            found <= 1'b1;
            state <= ST_HIT;
          end else if (cnt == SLOT_W'(TASK_SLOTS - 1)) begin
            state <= ST_FINISH;
          end else begin
            ptr <= ptr_wrap;
            cnt <= cnt + 1'b1;
          end
        end
        ST_HIT: begin
          prod <= 32'(ptr_inc) * 32'(STACK_BYTES);
          if (is_create) begin
            prev_idx <= '0;
            prev_ok  <= 1'b0;
          end else begin
            prev_idx  <= cur_valid ? cur_slot : '0;
            prev_ok   <= cur_valid;
            cur_slot  <= ptr;
            cur_valid <= 1'b1;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= status_out;
            if (found) begin
              m_tdata <= {7'd0, stack_ptr, start_addr, prev_ok,
                          prev_wide[INDEX_W-1:0], idx_wide[INDEX_W-1:0]};
            end else begin
              m_tdata <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/rrts_ram.sv @@
module rrts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rrts_slot_table.sv @@
module rrts_slot_table
  import rrts_pkg::*;
#(
  parameter int TASK_SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  slot_cmd_t                     cmd,
  input  logic [$clog2(TASK_SLOTS)-1:0] ptr,
  input  logic                          cur_valid,
  input  logic [$clog2(TASK_SLOTS)-1:0] cur_slot,
  output logic                          hit
);

  localparam int SLOT_W = $clog2(TASK_SLOTS);

  logic [1:0] status [TASK_SLOTS];

  // One slot is examined per cycle at the scan pointer.
  assign hit = (status[ptr] == (cmd.seek_unused ? SLOT_UNUSED : SLOT_READY));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
        status[j] <= SLOT_UNUSED;
      end
    end else begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
        if (cmd.free_cur && cur_slot == SLOT_W'(j)) begin
          status[j] <= SLOT_UNUSED;
        end
        if (cmd.create_set && ptr == SLOT_W'(j)) begin
          status[j] <= SLOT_READY;
        end
        if (cmd.switch_set) begin
          // A freed current slot stays freed; the chosen slot wins if both match.
          if (ptr == SLOT_W'(j)) begin
            status[j] <= SLOT_RUNNING;
          end else if (cur_valid && cur_slot == SLOT_W'(j) && status[j] != SLOT_UNUSED) begin
            status[j] <= SLOT_READY;
          end
        end
      end
    end
  end

endmodule

@@ bench/rrts_response_checker.sv @@
`timescale 1ns / 1ps

module rrts_response_checker
  import rrts_pkg::*;
#(
  parameter int TASK_SLOTS  = 16,
  parameter int STACK_BYTES = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic [31:0]           prdata,
  input  logic                  pready,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] entry_address
  input  logic [1:0]            s_tuser,   // [1:0] mode
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] task_index, [7:4] previous_index,
                                           // [8] previous_valid, [40:9] start_address,
                                           // [72:41] initial_stack, [79:73] zero
  input  logic [1:0]            m_tuser,   // [1:0] status
  output int                    mismatches,
  output int                    outstanding,
  output int                    responses_checked,
  output int                    switches_seen,
  output int                    full_seen
);

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  task_index;
    logic [3:0]  previous_index;
    logic        previous_valid;
    logic [31:0] start_address;
    logic [31:0] initial_stack;
  } sched_response_t;

  logic [1:0]  slot_state [TASK_SLOTS];
  logic [31:0] slot_entry_addr [TASK_SLOTS];
  logic        running_valid;
  int unsigned running_slot;
  logic [31:0] stack_base;
  sched_response_t expected_responses[$];

  function automatic logic [31:0] stack_top_of(int unsigned slot);
    return stack_base + 32'((slot + 1) * STACK_BYTES) - 32'd4;
  endfunction

  // Round-robin search for a ready slot, starting after the running task.
  function automatic sched_response_t pick_next_ready();
    sched_response_t resp;
    int unsigned first;
    int unsigned idx;
    int unsigned pick;
    logic found;
    resp = '0;
    resp.status = STATUS_NONE;
    first = running_valid ? (running_slot + 1) % TASK_SLOTS : 0;
    found = 1'b0;
    pick = 0;
    for (int k = 0; k < TASK_SLOTS; k++) begin
      idx = (first + k) % TASK_SLOTS;
      if (!found && slot_state[idx] == SLOT_READY) begin
        found = 1'b1;
        pick = idx;
      end
    end
    if (found) begin
      if (running_valid && slot_state[running_slot] != SLOT_UNUSED)
        slot_state[running_slot] = SLOT_READY;
      resp.status = STATUS_SWITCHED;
      resp.task_index = pick[3:0];
      resp.previous_index = running_valid ? running_slot[3:0] : 4'd0;
      resp.previous_valid = running_valid;
      resp.start_address = slot_entry_addr[pick];
      resp.initial_stack = stack_top_of(pick);
      slot_state[pick] = SLOT_RUNNING;
      running_slot = pick;
      running_valid = 1'b1;
    end
    return resp;
  endfunction

  function automatic sched_response_t schedule_request(logic [1:0] mode, logic [31:0] entry);
    sched_response_t resp;
    logic placed;
    resp = '0;
    resp.status = STATUS_NONE;
    case (mode)
      MODE_CREATE: begin
        placed = 1'b0;
        resp.status = STATUS_FULL;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (!placed && slot_state[i] == SLOT_UNUSED) begin
            placed = 1'b1;
            slot_state[i] = SLOT_READY;
            slot_entry_addr[i] = entry;
            resp.status = STATUS_CREATED;
            resp.task_index = i[3:0];
            resp.start_address = entry;
            resp.initial_stack = stack_top_of(i);
          end
        end
      end
      MODE_YIELD: resp = pick_next_ready();
      MODE_EXIT: begin
        if (running_valid)
          slot_state[running_slot] = SLOT_UNUSED;
        resp = pick_next_ready();
      end
      default: ;
    endcase
    return resp;
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("response %0d: %s is 0x%0h, expected 0x%0h",
                             responses_checked, field, got, want));
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    responses_checked = 0;
    switches_seen = 0;
    full_seen = 0;
  end

  always @(posedge clk) begin
    sched_response_t want;
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state[i] = SLOT_UNUSED;
        slot_entry_addr[i] = '0;
      end
      running_valid = 1'b0;
      running_slot = 0;
      stack_base = '0;
      expected_responses.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite && paddr == REG_STACK_BASE)
          stack_base = pwdata;
        else if (!pwrite && paddr == REG_STACK_BASE)
          check_field("stack base readback", prdata, stack_base);
      end
      // Responses are handled before requests so that a response arriving with
      // nothing pending is never matched against a request taken at the same edge.
      if (m_tvalid && m_tready) begin
        if (expected_responses.size() == 0) begin
          report_error($sformatf("response with no request pending, status %0d", m_tuser));
        end else begin
          want = expected_responses.pop_front();
          check_field("status", m_tuser, want.status);
          check_field("task_index", m_tdata[3:0], want.task_index);
          check_field("previous_index", m_tdata[7:4], want.previous_index);
          check_field("previous_valid", m_tdata[8], want.previous_valid);
          check_field("start_address", m_tdata[40:9], want.start_address);
          check_field("initial_stack", m_tdata[72:41], want.initial_stack);
          check_field("padding", m_tdata[79:73], 32'd0);
          if (want.status == STATUS_SWITCHED)
            switches_seen++;
          if (want.status == STATUS_FULL)
            full_seen++;
        end
        responses_checked++;
      end
      if (s_tvalid && s_tready)
        expected_responses.push_back(schedule_request(s_tuser, s_tdata[31:0]));
    end
    outstanding = expected_responses.size();
  end

endmodule

@@ bench/tb_round_robin_task_scheduler_core.sv @@
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler_core;
  import rrts_pkg::*;

  localparam int TASK_SLOTS  = 16;
  localparam int STACK_BYTES = 4096;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [31:0] entry_address
  logic [1:0]            s_tuser;   // [1:0] mode
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [3:0] task_index, [7:4] previous_index,
                                    // [8] previous_valid, [40:9] start_address,
                                    // [72:41] initial_stack, [79:73] zero
  logic [1:0]            m_tuser;   // [1:0] status

  int mismatches;
  int outstanding;
  int responses_checked;
  int switches_seen;
  int full_seen;

  int  cycle_count;
  int  sent_by_mode [3];
  int  base_settings;
  bit  quiet;
  bit  hold_responses;

  round_robin_task_scheduler_core #(
    .TASK_SLOTS (TASK_SLOTS),
    .STACK_BYTES(STACK_BYTES)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  rrts_response_checker #(
    .TASK_SLOTS (TASK_SLOTS),
    .STACK_BYTES(STACK_BYTES)
  ) checker_i (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tuser          (m_tuser),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .responses_checked(responses_checked),
    .switches_seen    (switches_seen),
    .full_seen        (full_seen)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_count, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  // Response side: a random stall before each response, and one long hold-off
  // on request from the stimulus so that the block backs up its input.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_responses) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_responses = 1'b0;
      end
      stall = quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken,
  // leaving s_tvalid high so that a back-to-back request needs no second assignment.
  task automatic send_request(logic [1:0] mode, logic [31:0] entry);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= entry;
    sent_by_mode[mode]++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_responses();
    s_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_stack_base(logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_STACK_BASE;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    // Read it back; the checker compares prdata during the access cycle.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    base_settings++;
  endtask

  // Creates slightly outnumber exits, so the table drifts between empty and full.
  task automatic run_random_requests(int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_request(MODE_CREATE, $urandom());
      else if (pick < 75)
        send_request(MODE_YIELD, $urandom());
      else
        send_request(MODE_EXIT, $urandom());
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = MODE_YIELD;
    quiet = 1'b0;
    hold_responses = 1'b0;
    cycle_count = 0;
    base_settings = 0;
    sent_by_mode = '{default: 0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty table: nothing to switch to, and an exit with no task acts as a yield.
    send_request(MODE_YIELD, 32'h0000_0000);
    send_request(MODE_EXIT, 32'hFFFF_FFFF);
    send_request(MODE_CREATE, 32'h0000_0000);
    send_request(MODE_CREATE, 32'hFFFF_FFFF);
    // First switch has no previous task; the second one does.
    send_request(MODE_YIELD, 32'hAAAA_AAAA);
    send_request(MODE_YIELD, 32'h5555_5555);
    // Exit the running task, then exit the last one; the freed slot must stay freed.
    send_request(MODE_EXIT, 32'h0);
    send_request(MODE_EXIT, 32'h0);
    send_request(MODE_YIELD, 32'h0);
    // Fill every slot, then one create too many.
    for (int i = 0; i < TASK_SLOTS; i++)
      send_request(MODE_CREATE, (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ i);
    send_request(MODE_CREATE, 32'h1234_5678);
    drain_responses();

    set_stack_base(32'hFFFF_FFFF);
    run_random_requests(160);
    drain_responses();

    set_stack_base($urandom());
    hold_responses = 1'b1;
    run_random_requests(160);
    drain_responses();

    set_stack_base(32'h0000_0000);
    quiet = 1'b1;
    run_random_requests(80);
    quiet = 1'b0;
    run_random_requests(80);
    drain_responses();

    set_stack_base(32'hFFFF_0000);
    run_random_requests(160);
    drain_responses();

    repeat (40) @(negedge clk);

    $display("Sent %0d creates, %0d yields and %0d exits under %0d stack base settings.",
             sent_by_mode[MODE_CREATE], sent_by_mode[MODE_YIELD], sent_by_mode[MODE_EXIT],
             base_settings);
    $display("Checked %0d responses: %0d task switches, %0d full-table replies, %0d errors.",
             responses_checked, switches_seen, full_seen, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/rrts_pkg.sv
rtl/rrts_ram.sv
rtl/rrts_slot_table.sv
rtl/round_robin_task_scheduler_core.sv
bench/rrts_response_checker.sv
bench/tb_round_robin_task_scheduler_core.sv
